// ===== rtl/qwsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsa_pkg
// Shared types, sizes, codes and the quality-indexed score tables of the
// quality weighted semi-global aligner. Tables are built at elaboration.
// ----------------------------------------------------------------------------
package qwsa_pkg;

	// Sizes
	localparam int MAX_SUBJECT  = 128;
	localparam int MAX_QUERY    = 128;
	localparam int SCORE_BITS   = 32;
	localparam int COLS         = MAX_QUERY + 1;
	localparam int PATH_MAX     = MAX_SUBJECT + MAX_QUERY;
	localparam int PHRED_LEVELS = 95;
	localparam int LEN_W        = 8;
	localparam int IDX_W        = 7;
	localparam int BASE_W       = 8;
	localparam int QUAL_W       = 7;
	localparam int SUBJ_AW      = $clog2(MAX_SUBJECT);
	localparam int QRY_AW       = $clog2(MAX_QUERY);
	localparam int ROW_AW       = $clog2(COLS);
	localparam int DIR_DEPTH    = (MAX_SUBJECT + 1) * COLS;
	localparam int DIR_AW       = $clog2(DIR_DEPTH);
	localparam int PATH_AW      = $clog2(PATH_MAX);
	localparam int CNT_W        = $clog2(PATH_MAX + 1);
	localparam int PH_W         = $clog2(PHRED_LEVELS);

	// Character codes
	localparam logic [BASE_W-1:0] WILDCARD    = 8'd78;
	localparam logic [QUAL_W-1:0] QUAL_OFFSET = 7'd33;

	// Fixed point constants (unsigned Q0.32 probabilities)
	localparam logic [63:0] ONE_Q32         = 64'h1_0000_0000;
	localparam logic [63:0] LN2_Q32         = 64'd2977044472;
	localparam logic [63:0] DECADE_STEP_Q32 = 64'd3411613790;
	localparam logic [63:0] PCR_ERR_Q32     = 64'd1402073;

	typedef logic signed [SCORE_BITS-1:0] score_t;

	// One matrix cell: score, log P(S|L), log P(S|L')
	typedef struct packed {
		score_t h;
		score_t sl;
		score_t slp;
	} cell_t;

	typedef enum logic [1:0] {
		OP_LOAD_SUBJ  = 2'd0,
		OP_LOAD_QUERY = 2'd1,
		OP_RUN        = 2'd2,
		OP_READ       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MV_MATCH     = 3'd0,
		MV_MISMATCH  = 3'd1,
		MV_QUERY_N   = 3'd2,
		MV_SUBJ_GAP  = 3'd3,
		MV_QUERY_GAP = 3'd4
	} move_t;

	typedef enum logic [1:0] {
		TK_MATCH_SCORE    = 2'd0,
		TK_MISMATCH_SCORE = 2'd1,
		TK_MATCH_EV       = 2'd2,
		TK_MISMATCH_EV    = 2'd3
	} tab_kind_t;

	typedef score_t score_tab_t [PHRED_LEVELS];

	// -ln(p) in Q15.16 for p in Q0.32, log2 by repeated squaring
	function automatic logic [31:0] neg_ln_q16(input logic [63:0] p_in);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] w;
		logic [63:0] frac;
		logic [63:0] k;
		logic [63:0] nl2;
		p    = (p_in == 64'd0) ? 64'd1 : p_in;
		k    = 64'd0;
		frac = 64'd0;
		if (p >= ONE_Q32) begin
			return 32'd0;
		end
		v = p;
		for (int s = 0; s < 33; s++) begin
			if (v < ONE_Q32) begin
				v = v << 1;
				k = k + 64'd1;
			end
		end
		w = v >> 2;
		for (int b = 0; b < 24; b++) begin
			w    = (w * w) >> 30;
			frac = frac << 1;
			if (w >= (64'd1 << 31)) begin
				w    = w >> 1;
				frac = frac | 64'd1;
			end
		end
		nl2 = (k << 24) - frac;
		return 32'((nl2 * LN2_Q32 + (64'd1 << 39)) >> 40);
	endfunction

	function automatic score_t neg_score(input logic [63:0] p);
		return score_t'(-longint'(neg_ln_q16(p)));
	endfunction

	// Per-phred tables of scores and evidence
	function automatic score_tab_t build_tab(input tab_kind_t kind);
		score_tab_t   tab;
		logic [127:0] m;
		logic [127:0] e;
		logic [127:0] one;
		logic [127:0] corr;
		logic [127:0] pm;
		logic [127:0] px;
		logic [31:0]  lm;
		logic [31:0]  lx;
		logic [31:0]  nq;
		logic [31:0]  n34;
		one = 128'(ONE_Q32);
		m   = one;
		e   = 128'(PCR_ERR_Q32);
		nq  = neg_ln_q16(64'd1 << 30);
		n34 = neg_ln_q16(64'd3 << 30);
		for (int p = 0; p < PHRED_LEVELS; p++) begin
			corr = one - m;
			pm   = (e * m + corr * (one - e) + (128'd1 << 31)) >> 32;
			px   = ((m * (one - e)) / 3 + (corr * e) / 3 + (128'd2 * m * e) / 9
				+ (128'd1 << 31)) >> 32;
			lm   = neg_ln_q16(pm[63:0]);
			lx   = neg_ln_q16(px[63:0]);
			case (kind)
				TK_MATCH_SCORE:    tab[p] = score_t'(longint'(nq) - longint'(lm));
				TK_MISMATCH_SCORE: tab[p] = score_t'(longint'(n34) - longint'(lx));
				TK_MATCH_EV:       tab[p] = score_t'(-longint'(lm));
				default:           tab[p] = score_t'(-longint'(lx));
			endcase
			m = (m * 128'(DECADE_STEP_Q32) + (128'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam score_tab_t TAB_MATCH_SCORE    = build_tab(TK_MATCH_SCORE);
	localparam score_tab_t TAB_MISMATCH_SCORE = build_tab(TK_MISMATCH_SCORE);
	localparam score_tab_t TAB_MATCH_EV       = build_tab(TK_MATCH_EV);
	localparam score_tab_t TAB_MISMATCH_EV    = build_tab(TK_MISMATCH_EV);
	localparam score_t     GAP_SCORE          = neg_score(PCR_ERR_Q32);
	localparam score_t     BG_MATCH_EV        = neg_score(64'd1 << 30);
	localparam score_t     BG_MISMATCH_EV     = neg_score(64'd3 << 30);

	// Saturating add to SCORE_BITS
	function automatic score_t sat_add(input score_t a, input score_t b);
		logic signed [SCORE_BITS:0] s;
		s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
		if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
			return s[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
				: {1'b0, {(SCORE_BITS-1){1'b1}}};
		end
		return s[SCORE_BITS-1:0];
	endfunction

endpackage

// ===== rtl/qwsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qwsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/qwsa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsa_cell
// Two-step cell update: diagonal and gap candidates are registered, then the
// winner and its evidence sums are selected for write-back.
// ----------------------------------------------------------------------------
module qwsa_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [qwsa_pkg::BASE_W-1:0]       sb,
	input  logic [qwsa_pkg::BASE_W-1:0]       qb,
	input  logic [qwsa_pkg::QUAL_W-1:0]       qv,
	input  qwsa_pkg::cell_t                   diag,
	input  qwsa_pkg::cell_t                   up,
	input  qwsa_pkg::cell_t                   left,
	output qwsa_pkg::cell_t                   new_cell,
	output qwsa_pkg::move_t                   mv
);
	import qwsa_pkg::*;

	logic [QUAL_W-1:0] ph_raw;
	logic [PH_W-1:0]   ph;
	score_t            dsc;
	score_t            dev;
	score_t            dbg;
	move_t             dmv;

	score_t  dv_s2;
	score_t  gi_s2;
	score_t  gj_s2;
	score_t  dev_s2;
	score_t  dbg_s2;
	move_t   dmv_s2;
	cell_t   diag_s2;
	cell_t   up_s2;
	cell_t   left_s2;

	// Phred index, clamped to the table
	always_comb begin
		ph_raw = (qv < QUAL_OFFSET) ? '0 : qv - QUAL_OFFSET;
		if (int'(ph_raw) >= PHRED_LEVELS) begin
			ph = PH_W'(PHRED_LEVELS - 1);
		end else begin
			ph = ph_raw[PH_W-1:0];
		end
	end

	// Diagonal step kind and table scores
	always_comb begin
		if (sb == qb) begin
			dmv = MV_MATCH;
			dsc = TAB_MATCH_SCORE[ph];
			dev = TAB_MATCH_EV[ph];
			dbg = BG_MATCH_EV;
		end else if (qb == WILDCARD) begin
			dmv = MV_QUERY_N;
			dsc = '0;
			dev = '0;
			dbg = '0;
		end else begin
			dmv = MV_MISMATCH;
			dsc = TAB_MISMATCH_SCORE[ph];
			dev = TAB_MISMATCH_EV[ph];
			dbg = BG_MISMATCH_EV;
		end
	end

	// Candidate register
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s2   <= sat_add(diag.h, dsc);
			gi_s2   <= sat_add(up.h, GAP_SCORE);
			gj_s2   <= sat_add(left.h, GAP_SCORE);
			dev_s2  <= dev;
			dbg_s2  <= dbg;
			dmv_s2  <= dmv;
			diag_s2 <= diag;
			up_s2   <= up;
			left_s2 <= left;
		end
	end

	// Select: diagonal wins ties, then subject gap
	always_comb begin
		if (gi_s2 > dv_s2 && gi_s2 >= gj_s2) begin
			mv           = MV_SUBJ_GAP;
			new_cell.h   = gi_s2;
			new_cell.sl  = sat_add(up_s2.sl, GAP_SCORE);
			new_cell.slp = up_s2.slp;
		end else if (gj_s2 > dv_s2 && gj_s2 > gi_s2) begin
			mv           = MV_QUERY_GAP;
			new_cell.h   = gj_s2;
			new_cell.sl  = sat_add(left_s2.sl, GAP_SCORE);
			new_cell.slp = left_s2.slp;
		end else begin
			mv           = dmv_s2;
			new_cell.h   = dv_s2;
			new_cell.sl  = sat_add(diag_s2.sl, dev_s2);
			new_cell.slp = sat_add(diag_s2.slp, dbg_s2);
		end
	end

endmodule

// ===== rtl/quality_weighted_semiglobal_aligner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_weighted_semiglobal_aligner
// Loads bases, fills a quality-weighted log-likelihood matrix row by row
// from on-chip memories, traces back the best end cell and reads moves out.
// ----------------------------------------------------------------------------
// Run: a clear pass over row 0, the fill, the end-cell pick (last column,
//      then end cell) and the traceback. Each cell goes through a row RAM
//      read, a candidate stage and a write-back before the next starts.
// One request in flight; the next is taken while a result waits at the output.
// Reset clears control, summary, path count and read pointer; the base,
// row, direction and path memories hold no reset value; only the row
// memory gets a clear pass, at the start of each run.
module quality_weighted_semiglobal_aligner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// index[6:0], base[14:7], quality[21:15], subject_length[29:22],
	// query_length[37:30], zero[39:38]
	input  logic [39:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// move[2:0], best_score[34:3], end_subject[42:35], end_query[50:43],
	// not_linker[51], path_length[60:52], zero[63:61]
	output logic [63:0] m_tdata,
	// status[0]
	output logic [0:0]  m_tuser,
	// last_move
	output logic        m_tlast
);
	import qwsa_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE      = 13'b0000000000001,
		ST_EXEC      = 13'b0000000000010,
		ST_CLEAR     = 13'b0000000000100,
		ST_ROW       = 13'b0000000001000,
		ST_CELL_RD   = 13'b0000000010000,
		ST_CELL_DG   = 13'b0000000100000,
		ST_CELL_WR   = 13'b0000001000000,
		ST_PICK_COL  = 13'b0000010000000,
		ST_PICK_END  = 13'b0000100000000,
		ST_TB_RD     = 13'b0001000000000,
		ST_TB_STEP   = 13'b0010000000000,
		ST_PATH_DATA = 13'b0100000000000,
		ST_FINISH    = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Request fields
	op_t               req_op_q;
	logic [IDX_W-1:0]  req_idx_q;
	logic [BASE_W-1:0] req_base_q;
	logic [QUAL_W-1:0] req_qual_q;
	logic [LEN_W-1:0]  req_slen_q;
	logic [LEN_W-1:0]  req_qlen_q;

	// Run control
	logic [LEN_W-1:0] sl_q;
	logic [LEN_W-1:0] ql_q;
	logic [LEN_W-1:0] i_q;
	logic [LEN_W-1:0] j_q;
	logic [LEN_W-1:0] im1;
	logic [LEN_W-1:0] jm1;
	cell_t            diag_q;
	cell_t            left_q;
	cell_t            colbest_q;
	logic [LEN_W-1:0] colbest_i_q;
	cell_t            collast_q;
	cell_t            rowbest_q;
	logic [LEN_W-1:0] rowbest_j_q;
	logic             row_valid_q;
	cell_t            colres_q;
	logic [LEN_W-1:0] colres_i_q;
	logic [CNT_W-1:0] n_q;
	move_t            tb_mv;

	// Summary and readout
	score_t           sum_best_q;
	logic [LEN_W-1:0] sum_es_q;
	logic [LEN_W-1:0] sum_eq_q;
	logic             sum_nl_q;
	logic [CNT_W-1:0] path_count_q;
	logic [CNT_W-1:0] rp_q;
	logic [CNT_W-1:0] path_raddr;

	// Per-request result
	logic  res_status_q;
	move_t res_move_q;
	logic  res_last_q;

	// Output register
	logic             out_valid_q;
	logic             out_status_q;
	move_t            out_move_q;
	logic             out_last_q;
	score_t           out_best_q;
	logic [LEN_W-1:0] out_es_q;
	logic [LEN_W-1:0] out_eq_q;
	logic             out_nl_q;
	logic [CNT_W-1:0] out_plen_q;

	// Memory ports
	logic [BASE_W-1:0]          subj_rdata;
	logic [QUAL_W+BASE_W-1:0]   qry_rdata;
	cell_t                      row_rdata;
	cell_t                      row_wdata;
	logic [2:0]                 dir_rdata;
	logic [2:0]                 path_rdata;
	logic [DIR_AW-1:0]          dir_addr;
	cell_t                      cell_new;
	move_t                      cell_mv;
	logic                       finish_go;

	assign im1        = i_q - LEN_W'(1);
	assign jm1        = j_q - LEN_W'(1);
	assign dir_addr   = DIR_AW'(int'(i_q) * COLS + int'(j_q));
	assign path_raddr = path_count_q - CNT_W'(1) - rp_q;
	assign row_wdata  = (state_q == ST_CLEAR) ? '0 : cell_new;
	assign finish_go  = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	// Base stores
	qwsa_ram #(.WIDTH(BASE_W), .DEPTH(MAX_SUBJECT)) u_subj (
		.clk   (clk),
		.we    (state_q == ST_EXEC && req_op_q == OP_LOAD_SUBJ
			&& int'(req_idx_q) < MAX_SUBJECT),
		.waddr (SUBJ_AW'(req_idx_q)),
		.wdata (req_base_q),
		.re    (state_q == ST_ROW),
		.raddr (im1[SUBJ_AW-1:0]),
		.rdata (subj_rdata)
	);

	qwsa_ram #(.WIDTH(QUAL_W + BASE_W), .DEPTH(MAX_QUERY)) u_qry (
		.clk   (clk),
		.we    (state_q == ST_EXEC && req_op_q == OP_LOAD_QUERY
			&& int'(req_idx_q) < MAX_QUERY),
		.waddr (QRY_AW'(req_idx_q)),
		.wdata ({req_qual_q, req_base_q}),
		.re    (state_q == ST_CELL_RD),
		.raddr (jm1[QRY_AW-1:0]),
		.rdata (qry_rdata)
	);

	// Working row: score and both evidence sums
	qwsa_ram #(.WIDTH($bits(cell_t)), .DEPTH(COLS)) u_row (
		.clk   (clk),
		.we    (state_q == ST_CLEAR || state_q == ST_CELL_WR),
		.waddr (ROW_AW'(j_q)),
		.wdata (row_wdata),
		.re    (state_q == ST_CELL_RD),
		.raddr (ROW_AW'(j_q)),
		.rdata (row_rdata)
	);

	// Direction matrix
	qwsa_ram #(.WIDTH(3), .DEPTH(DIR_DEPTH)) u_dir (
		.clk   (clk),
		.we    (state_q == ST_CELL_WR),
		.waddr (dir_addr),
		.wdata (cell_mv),
		.re    (state_q == ST_TB_RD),
		.raddr (dir_addr),
		.rdata (dir_rdata)
	);

	// Path, stored in traceback order and read back reversed
	qwsa_ram #(.WIDTH(3), .DEPTH(PATH_MAX)) u_path (
		.clk   (clk),
		.we    (state_q == ST_TB_STEP),
		.waddr (n_q[PATH_AW-1:0]),
		.wdata (tb_mv),
		.re    (state_q == ST_EXEC && req_op_q == OP_READ && rp_q < path_count_q),
		.raddr (path_raddr[PATH_AW-1:0]),
		.rdata (path_rdata)
	);

	qwsa_cell u_cell (
		.clk      (clk),
		.en       (state_q == ST_CELL_DG),
		.sb       (subj_rdata),
		.qb       (qry_rdata[BASE_W-1:0]),
		.qv       (qry_rdata[QUAL_W+BASE_W-1:BASE_W]),
		.diag     (diag_q),
		.up       (row_rdata),
		.left     (left_q),
		.new_cell (cell_new),
		.mv       (cell_mv)
	);

	// Traceback move at the current coordinate
	always_comb begin
		if (i_q == '0) begin
			tb_mv = MV_QUERY_GAP;
		end else if (j_q == '0) begin
			tb_mv = MV_SUBJ_GAP;
		end else begin
			tb_mv = move_t'(dir_rdata);
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_op_q   <= op_t'(s_tuser);
			req_idx_q  <= s_tdata[6:0];
			req_base_q <= s_tdata[14:7];
			req_qual_q <= s_tdata[21:15];
			req_slen_q <= s_tdata[29:22];
			req_qlen_q <= s_tdata[37:30];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			path_count_q <= '0;
			rp_q         <= '0;
			sum_best_q   <= '0;
			sum_es_q     <= '0;
			sum_eq_q     <= '0;
			sum_nl_q     <= 1'b0;
			row_valid_q  <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_move_q <= MV_MATCH;
					res_last_q <= (req_op_q == OP_READ) && (rp_q < path_count_q)
						&& (rp_q + CNT_W'(1) == path_count_q);
					case (req_op_q)
						OP_LOAD_SUBJ: begin
							res_status_q <= !(int'(req_idx_q) < MAX_SUBJECT);
							state_q      <= ST_FINISH;
						end
						OP_LOAD_QUERY: begin
							res_status_q <= !(int'(req_idx_q) < MAX_QUERY);
							state_q      <= ST_FINISH;
						end
						OP_RUN: begin
							if (req_slen_q == '0 || int'(req_slen_q) > MAX_SUBJECT
								|| req_qlen_q == '0 || int'(req_qlen_q) > MAX_QUERY) begin
								res_status_q <= 1'b1;
								state_q      <= ST_FINISH;
							end else begin
								res_status_q <= 1'b0;
								sl_q         <= req_slen_q;
								ql_q         <= req_qlen_q;
								j_q          <= '0;
								row_valid_q  <= 1'b0;
								state_q      <= ST_CLEAR;
							end
						end
						default: begin
							if (rp_q < path_count_q) begin
								res_status_q <= 1'b0;
								rp_q         <= rp_q + CNT_W'(1);
								state_q      <= ST_PATH_DATA;
							end else begin
								res_status_q <= 1'b1;
								state_q      <= ST_FINISH;
							end
						end
					endcase
				end
				ST_CLEAR: begin
					if (j_q == ql_q) begin
						i_q     <= LEN_W'(1);
						state_q <= ST_ROW;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				ST_ROW: begin
					j_q     <= LEN_W'(1);
					diag_q  <= '0;
					left_q  <= '0;
					state_q <= ST_CELL_RD;
				end
				ST_CELL_RD: begin
					state_q <= ST_CELL_DG;
				end
				ST_CELL_DG: begin
					state_q <= ST_CELL_WR;
				end
				ST_CELL_WR: begin
					diag_q <= row_rdata;
					left_q <= cell_new;
					// End-cell candidates: last column, then last row
					if (j_q == ql_q) begin
						if (i_q == LEN_W'(1) || cell_new.h > colbest_q.h) begin
							colbest_q   <= cell_new;
							colbest_i_q <= i_q;
						end
						if (i_q == sl_q) begin
							collast_q <= cell_new;
						end
					end else if (i_q == sl_q && (!row_valid_q || cell_new.h > rowbest_q.h)) begin
						rowbest_q   <= cell_new;
						rowbest_j_q <= j_q;
						row_valid_q <= 1'b1;
					end
					if (j_q == ql_q) begin
						if (i_q == sl_q) begin
							state_q <= ST_PICK_COL;
						end else begin
							i_q     <= i_q + LEN_W'(1);
							state_q <= ST_ROW;
						end
					end else begin
						j_q     <= j_q + LEN_W'(1);
						state_q <= ST_CELL_RD;
					end
				end
				ST_PICK_COL: begin
					if (colbest_q.h > collast_q.h) begin
						colres_q   <= colbest_q;
						colres_i_q <= colbest_i_q;
					end else begin
						colres_q   <= collast_q;
						colres_i_q <= sl_q;
					end
					state_q <= ST_PICK_END;
				end
				ST_PICK_END: begin
					if (row_valid_q && rowbest_q.h > colres_q.h) begin
						sum_best_q <= rowbest_q.h;
						sum_nl_q   <= rowbest_q.sl < rowbest_q.slp;
						sum_es_q   <= sl_q;
						sum_eq_q   <= rowbest_j_q;
						i_q        <= sl_q;
						j_q        <= rowbest_j_q;
					end else begin
						sum_best_q <= colres_q.h;
						sum_nl_q   <= colres_q.sl < colres_q.slp;
						sum_es_q   <= colres_i_q;
						sum_eq_q   <= ql_q;
						i_q        <= colres_i_q;
						j_q        <= ql_q;
					end
					n_q     <= '0;
					state_q <= ST_TB_RD;
				end
				ST_TB_RD: begin
					if (i_q == '0 && j_q == '0) begin
						path_count_q <= n_q;
						rp_q         <= '0;
						state_q      <= ST_FINISH;
					end else begin
						state_q <= ST_TB_STEP;
					end
				end
				ST_TB_STEP: begin
					n_q <= n_q + CNT_W'(1);
					case (tb_mv)
						MV_SUBJ_GAP: begin
							i_q <= im1;
						end
						MV_QUERY_GAP: begin
							j_q <= jm1;
						end
						default: begin
							i_q <= im1;
							j_q <= jm1;
						end
					endcase
					state_q <= ST_TB_RD;
				end
				ST_PATH_DATA: begin
					res_move_q <= move_t'(path_rdata);
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_status_q <= res_status_q;
			out_move_q   <= res_move_q;
			out_last_q   <= res_last_q;
			out_best_q   <= sum_best_q;
			out_es_q     <= sum_es_q;
			out_eq_q     <= sum_eq_q;
			out_nl_q     <= sum_nl_q;
			out_plen_q   <= path_count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_plen_q, out_nl_q, out_eq_q, out_es_q,
		32'(out_best_q), out_move_q};

	// Checks
	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= path_count_q)
		else $error("read pointer past path length");

	a_path_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(path_count_q) <= PATH_MAX)
		else $error("path length beyond maximum");

	a_tb_coord: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TB_STEP) |-> (i_q <= sl_q && j_q <= ql_q && int'(n_q) < PATH_MAX))
		else $error("traceback left the matrix");

endmodule
